// File: rtl/sha1md_pkg.sv
// Shared types and constants of the SHA-1 digest block.
`default_nettype none

package sha1md_pkg;

   // One message item as it travels from the front end to the engine.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       is_last;
   } item_type;

   // Head of the item queue as seen by the engine.
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = 1;

   typedef logic [31:0] word_type;

   localparam word_type H_INIT [5] = '{
      32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
   };

   localparam word_type K_00_19 = 32'h5A82_7999;
   localparam word_type K_20_39 = 32'h6ED9_EBA1;
   localparam word_type K_40_59 = 32'h8F1B_BCDC;
   localparam word_type K_60_79 = 32'hCA62_C1D6;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [7:0] PAD_ZERO = 8'h00;

   localparam logic [6:0] LAST_ROUND  = 7'd79;
   localparam logic [5:0] LEN_POS     = 6'd56;
   localparam logic [5:0] LAST_POS    = 6'd63;
   localparam logic [2:0] LAST_WORD   = 3'd4;

endpackage

`default_nettype wire

// File: rtl/sha1md_if.sv
// Handshake channels for message items and digest words.
`default_nettype none

interface sha1md_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       is_last;

   modport source (output valid, data_byte, has_byte, is_last, input ready);
   modport sink   (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface sha1md_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// File: rtl/sha1_message_digest.sv
// Top level of the SHA-1 digest block.
// Usage:
//   req_chan carries one message byte per transaction (data_byte, valid
//   when has_byte is set) and marks the end of a message with is_last.
//   A transaction with neither has_byte nor is_last is ignored.
//   rsp_chan returns the five digest words H0..H4 as five transactions,
//   word_index 0 to 4, last_word set on the fifth.
// Timing:
//   A two-entry queue accepts one transaction per cycle while it has room.
//   The engine packs one byte per cycle; every 64th byte adds a block
//   compression of 80 rounds followed by the chaining add.
//   After is_last, padding runs one byte per cycle up to byte 56 of a
//   block (a second compression first when the marker lands past byte 55),
//   then the two length words are pushed and the final compression runs;
//   the digest words leave at one per cycle while rsp_chan takes them. The
//   sustained byte rate is set by the single shared round unit.
// Reset: synchronous; clears the queue, restores the initial hash value
//   and drops any partly received message.
// Stalls: the digest sits in an output register; while rsp_chan is
//   stalled the engine waits and the queue keeps taking bytes until full.
`default_nettype none

module sha1_message_digest (
   input  wire logic    clock,
   input  wire logic    reset,
   sha1md_req_if.sink   req_chan,
   sha1md_rsp_if.source rsp_chan
);

   sha1md_pkg::queue_head_type q_head;
   logic                       q_pop;

   // accept and filter transactions
   sha1md_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_head   (q_head),
      .q_pop    (q_pop)
   );

   // pack, pad, compress, emit
   sha1md_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// File: rtl/sha1md_front.sv
// Front end: accepts message items, drops idle ones, queues the rest.
`default_nettype none

module sha1md_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   sha1md_req_if.sink                     req_chan,
   output sha1md_pkg::queue_head_type     q_head,
   input  wire logic                      q_pop
);

   sha1md_pkg::item_type entry_ff [sha1md_pkg::QUEUE_DEPTH];
   logic [sha1md_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sha1md_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sha1md_pkg::QPTR_W:0]   fill_ff, fill_in;
   logic                          push;
   logic                          pop;

   assign req_chan.ready = (fill_ff != (sha1md_pkg::QPTR_W+1)'(sha1md_pkg::QUEUE_DEPTH));

   // idle items carry nothing and are dropped here
   assign push = req_chan.valid && req_chan.ready
                 && (req_chan.has_byte || req_chan.is_last);
   assign pop  = q_pop && (fill_ff != '0);

   assign q_head.valid = (fill_ff != '0);
   assign q_head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{data_byte: req_chan.data_byte,
                                  has_byte:  req_chan.has_byte,
                                  is_last:   req_chan.is_last};
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sha1md_engine.sv
// Back end: byte packing, padding, 80-round compression and digest output.
`default_nettype none

module sha1md_engine (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sha1md_pkg::queue_head_type q_head,
   output logic                           q_pop,
   sha1md_rsp_if.source                   rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   state_type   state_ff, state_in;
   logic [31:0] chain_ff [5];
   logic [31:0] chain_in [5];
   logic [31:0] work_ff  [5];
   logic [31:0] work_in  [5];
   logic [31:0] win_ff   [16];
   logic [31:0] win_in   [16];
   logic [23:0] acc_ff, acc_in;
   logic [5:0]  count_ff, count_in;
   logic [63:0] len_ff, len_in;
   logic [6:0]  round_ff, round_in;
   logic        last_pend_ff, last_pend_in;
   logic        pad_done_ff, pad_done_in;
   logic        final_ff, final_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [2:0]  rsp_index_ff, rsp_index_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        put_en;
   logic [7:0]  put_data;
   logic        push_en;
   logic [31:0] push_word;
   logic        start;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] t_val;
   logic [31:0] w_next;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.digest_word = rsp_word_ff;
   assign rsp_chan.word_index  = rsp_index_ff;
   assign rsp_chan.last_word   = rsp_last_ff;

   // round function and constant
   always_comb begin
      if (round_ff < 7'd20) begin
         f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         k_val = sha1md_pkg::K_00_19;
      end else if (round_ff < 7'd40) begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = sha1md_pkg::K_20_39;
      end else if (round_ff < 7'd60) begin
         f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3])
                 | (work_ff[2] & work_ff[3]);
         k_val = sha1md_pkg::K_40_59;
      end else begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = sha1md_pkg::K_60_79;
      end
      t_val  = rotl(work_ff[0], 5) + f_val + work_ff[4] + k_val + win_ff[0];
      w_next = rotl(win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0], 1);
   end

   always_comb begin
      state_in     = state_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      win_in       = win_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      round_in     = round_ff;
      last_pend_in = last_pend_ff;
      pad_done_in  = pad_done_ff;
      final_in     = final_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in  = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      put_en       = 1'b0;
      put_data     = sha1md_pkg::PAD_ZERO;
      push_en      = 1'b0;
      push_word    = '0;
      start        = 1'b0;
      q_pop        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop        = 1'b1;
               last_pend_in = q_head.item.is_last;
               if (q_head.item.has_byte) begin
                  put_en   = 1'b1;
                  put_data = q_head.item.data_byte;
                  len_in   = len_ff + 64'd8;
               end
               if (q_head.item.is_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (!pad_done_ff) begin
               put_en      = 1'b1;
               put_data    = sha1md_pkg::PAD_MARK;
               pad_done_in = 1'b1;
            end else if (count_ff != sha1md_pkg::LEN_POS) begin
               put_en   = 1'b1;
               put_data = sha1md_pkg::PAD_ZERO;
            end else begin
               state_in = ST_LEN_HI;
            end
         end
         ST_LEN_HI: begin
            push_en   = 1'b1;
            push_word = len_ff[63:32];
            state_in  = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            push_en   = 1'b1;
            push_word = len_ff[31:0];
            count_in  = '0;
            final_in  = 1'b1;
            start     = 1'b1;
         end
         ST_ROUND: begin
            work_in[4] = work_ff[3];
            work_in[3] = work_ff[2];
            work_in[2] = rotl(work_ff[1], 30);
            work_in[1] = work_ff[0];
            work_in[0] = t_val;
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[15] = w_next;
            if (round_ff == sha1md_pkg::LAST_ROUND) begin
               round_in = '0;
               state_in = ST_ADD;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 5; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            if (final_ff) begin
               out_idx_in = '0;
               state_in   = ST_OUT;
            end else if (last_pend_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain_ff[out_idx_ff];
               rsp_index_in = out_idx_ff;
               rsp_last_in  = (out_idx_ff == sha1md_pkg::LAST_WORD);
               if (out_idx_ff == sha1md_pkg::LAST_WORD) begin
                  // digest handed over: back to a fresh message
                  chain_in     = sha1md_pkg::H_INIT;
                  count_in     = '0;
                  len_in       = '0;
                  last_pend_in = 1'b0;
                  pad_done_in  = 1'b0;
                  final_in     = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // byte packing, big-endian within each word
      if (put_en) begin
         acc_in   = {acc_ff[15:0], put_data};
         count_in = count_ff + 6'd1;
         if (count_ff[1:0] == 2'b11) begin
            push_en   = 1'b1;
            push_word = {acc_ff, put_data};
         end
         if (count_ff == sha1md_pkg::LAST_POS) begin
            start = 1'b1;
         end
      end

      if (push_en) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[15] = push_word;
      end

      if (start) begin
         work_in  = chain_ff;
         round_in = '0;
         state_in = ST_ROUND;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      win_ff       <= win_in;
      acc_ff       <= acc_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      out_idx_ff   <= out_idx_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         chain_ff     <= sha1md_pkg::H_INIT;
         count_ff     <= '0;
         len_ff       <= '0;
         round_ff     <= '0;
         last_pend_ff <= 1'b0;
         pad_done_ff  <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         round_ff     <= round_in;
         last_pend_ff <= last_pend_in;
         pad_done_ff  <= pad_done_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sha1md_checker.sv
// Port-level checks on the digest output of the SHA-1 block.
`default_nettype none

module sha1md_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] digest_word,
   input wire logic [2:0]  word_index,
   input wire logic        last_word
);

   // stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(digest_word) && $stable(word_index))
      else $error("stalled digest word changed");

   // last flag belongs to word four only
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (word_index <= 3'd4) && (last_word == (word_index == 3'd4)))
      else $error("bad word index or last flag");

   // words of one digest follow back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_word
      |=> rsp_valid && (word_index == $past(word_index) + 3'd1))
      else $error("digest words not contiguous");

   // nothing presented straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind sha1_message_digest sha1md_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .digest_word (rsp_chan.digest_word),
   .word_index  (rsp_chan.word_index),
   .last_word   (rsp_chan.last_word)
);

`default_nettype wire

// File: bench/sha1_message_digest_tb.sv
// Self-checking bench for the byte-streaming SHA-1 digest block.
`default_nettype none

module sha1_message_digest_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Watchdog: cycles without any transaction on either channel before the run is abandoned.
   // The slowest honest quiet stretch is the long receiver hold-off plus two
   // block compressions.
   localparam int WATCHDOG_LIMIT = 4000;
   // Length of the one deliberate receiver hold-off, in cycles.
   localparam int LONG_HOLD      = 600;
   // Cycles allowed after the last digest word for stray idle items to drain.
   localparam int DRAIN_CYCLES   = 250;
   // Rough count of random message transactions (idle noise not counted).
   localparam int RANDOM_ITEMS   = 120;

   // Receiver back-pressure styles, picked afresh for each stretch.
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_HALF,
      RX_SPARSE
   } rx_mode_type;

   // One expected digest word as it should leave rsp_chan.
   typedef struct {
      sha1md_pkg::word_type digest_word;
      logic [2:0]           word_index;
      logic                 last_word;
   } digest_beat_type;

   logic clock;
   logic reset;

   sha1md_req_if req_chan ();
   sha1md_rsp_if rsp_chan ();

   sha1_message_digest dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // ------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------
   sha1md_pkg::item_type pending_items [$];    // message transactions not yet accepted
   digest_beat_type      digest_beats_due [$]; // predicted digest words, oldest first

   int error_count  = 0;
   int digests_done = 0;   // completed digests seen on rsp_chan

   // Predictor's own copy of the hashing state.
   sha1md_pkg::word_type chain_state [5];
   sha1md_pkg::word_type msg_window [16];
   logic [5:0]           block_pos;
   logic [63:0]          message_bits;

   // ------------------------------------------------------------------
   // Error reporting: one line per problem, and a running count.
   // ------------------------------------------------------------------
   task automatic flag_error(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // SHA-1 predictor
   // ------------------------------------------------------------------
   function automatic sha1md_pkg::word_type rotate_left(input sha1md_pkg::word_type v,
                                                        input int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // Back to the start-of-message state: initial hash, empty block, zero length.
   task automatic clear_hash_state();
      for (int i = 0; i < 5; i++) chain_state[i] = sha1md_pkg::H_INIT[i];
      for (int i = 0; i < 16; i++) msg_window[i] = '0;
      block_pos    = '0;
      message_bits = '0;
   endtask

   // 80 rounds over the window, rolling schedule kept in place, then the chaining add.
   task automatic compress_window();
      sha1md_pkg::word_type a, b, c, d, e, f, k, tmp;
      a = chain_state[0];
      b = chain_state[1];
      c = chain_state[2];
      d = chain_state[3];
      e = chain_state[4];
      for (int t = 0; t <= int'(sha1md_pkg::LAST_ROUND); t++) begin
         if (t >= 16) begin
            msg_window[t % 16] = rotate_left(msg_window[(t - 3) % 16] ^ msg_window[(t - 8) % 16]
                                             ^ msg_window[(t - 14) % 16] ^ msg_window[t % 16], 1);
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = sha1md_pkg::K_00_19;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K_20_39;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1md_pkg::K_40_59;
         end else begin
            f = b ^ c ^ d;
            k = sha1md_pkg::K_60_79;
         end
         tmp = rotate_left(a, 5) + f + e + k + msg_window[t % 16];
         e = d;
         d = c;
         c = rotate_left(b, 30);
         b = a;
         a = tmp;
      end
      chain_state[0] += a;
      chain_state[1] += b;
      chain_state[2] += c;
      chain_state[3] += d;
      chain_state[4] += e;
   endtask

   // Big-endian packing; the first byte of a word overwrites it.
   task automatic absorb_byte(input logic [7:0] value);
      int unsigned shift;
      shift = (3 - block_pos[1:0]) * 8;
      if (block_pos[1:0] == 2'd0)
         msg_window[block_pos[5:2]] = sha1md_pkg::word_type'(value) << shift;
      else
         msg_window[block_pos[5:2]] |= sha1md_pkg::word_type'(value) << shift;
      if (block_pos == sha1md_pkg::LAST_POS) begin
         block_pos = '0;
         compress_window();
      end else begin
         block_pos = block_pos + 6'd1;
      end
   endtask

   // Works out what one accepted transaction causes; only an end of message
   // gives results, the five digest words.
   task automatic predict_digest(input logic [7:0] data_byte, input logic has_byte,
                                 input logic is_last);
      digest_beat_type beat;
      if (has_byte) begin
         message_bits = message_bits + 64'd8;
         absorb_byte(data_byte);
      end
      if (!is_last) return;
      absorb_byte(sha1md_pkg::PAD_MARK);
      while (block_pos != sha1md_pkg::LEN_POS) absorb_byte(sha1md_pkg::PAD_ZERO);
      msg_window[14] = message_bits[63:32];
      msg_window[15] = message_bits[31:0];
      block_pos = '0;
      compress_window();
      for (int i = 0; i < 5; i++) begin
         beat.digest_word = chain_state[i];
         beat.word_index  = 3'(i);
         beat.last_word   = (3'(i) == sha1md_pkg::LAST_WORD);
         digest_beats_due.push_back(beat);
      end
      clear_hash_state();
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic void queue_item(input logic [7:0] data_byte, input logic has_byte,
                                      input logic is_last);
      sha1md_pkg::item_type it;
      it.data_byte = data_byte;
      it.has_byte  = has_byte;
      it.is_last   = is_last;
      pending_items.push_back(it);
   endfunction

   // A message of random bytes, sprinkled with idle transactions. The end is marked
   // either on the final byte or by a separate byte-less transaction.
   // Returns the number of message transactions queued (idle noise excluded).
   function automatic int queue_random_message(input int length);
      bit end_on_byte;
      int queued;
      end_on_byte = (length > 0) && ($urandom_range(0, 1) == 1);
      queued = 0;
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(0, 7) == 0) queue_item(8'($urandom), 1'b0, 1'b0);
         queue_item(8'($urandom), 1'b1, end_on_byte && (i == length - 1));
         queued++;
      end
      if (!end_on_byte) begin
         queue_item(8'($urandom), 1'b0, 1'b1);
         queued++;
      end
      return queued;
   endfunction

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Main sequence: fill the transaction queue, reset once, then wait for the end.
   // ------------------------------------------------------------------
   initial begin
      int random_items;
      int length;
      int boundary_len [6];

      // Every block input known from time zero.
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.has_byte  = 1'b0;
      req_chan.is_last   = 1'b0;
      rsp_chan.ready     = 1'b0;
      clear_hash_state();

      // Directed part.
      // Empty message straight after reset.
      queue_item(8'h00, 1'b0, 1'b1);
      // An idle transaction must leave no trace; then a second empty message.
      queue_item(8'hA5, 1'b0, 1'b0);
      queue_item(8'h00, 1'b0, 1'b1);
      // Single-byte messages at both extremes of the byte.
      queue_item(8'hFF, 1'b1, 1'b1);
      queue_item(8'h00, 1'b1, 1'b1);
      // Classic "abc", end flagged on the last byte.
      queue_item(8'h61, 1'b1, 1'b0);
      queue_item(8'h62, 1'b1, 1'b0);
      queue_item(8'h63, 1'b1, 1'b1);
      // Idle in mid-message, end flagged by a byte-less transaction with junk data.
      queue_item(8'h61, 1'b1, 1'b0);
      queue_item(8'hFF, 1'b0, 1'b0);
      queue_item(8'h62, 1'b1, 1'b0);
      queue_item(8'hFF, 1'b0, 1'b1);
      // Restart check: same byte as before, must give the same digest again.
      queue_item(8'hFF, 1'b1, 1'b1);

      // Random part. Mostly short messages; now and then one whose length sits
      // on a padding or block boundary (marker fits / spills, full block).
      boundary_len = '{55, 56, 57, 63, 64, 65};
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) length = boundary_len[$urandom_range(0, 5)];
         else                           length = $urandom_range(0, 20);
         random_items += queue_random_message(length);
      end

      // Single reset pulse.
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // All transactions accepted and every digest word returned...
      while (pending_items.size() != 0 || digest_beats_due.size() != 0) @(posedge clock);
      // ...then let any trailing idle transaction work through the block.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (digest_beats_due.size() != 0) begin
         flag_error($sformatf("%0d digest words never arrived", digest_beats_due.size()));
      end

      if (error_count == 0) begin
         $display("[sha1_message_digest] OK");
      end else begin
         $display("[sha1_message_digest] ERROR");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Driver: offers the head of the queue in bursts with random gaps.
   // A transaction happens at an edge with valid and ready both high; the
   // accepted fields go straight to the predictor.
   // ------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left = $urandom_range(1, 12);
         gap_left   = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_digest(req_chan.data_byte, req_chan.has_byte, req_chan.is_last);
            void'(pending_items.pop_front());
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               // A quarter of bursts run straight on with no gap.
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         // One assignment per signal per edge: valid stays high across
         // back-to-back transactions.
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_chan.valid     <= 1'b1;
            req_chan.data_byte <= pending_items[0].data_byte;
            req_chan.has_byte  <= pending_items[0].has_byte;
            req_chan.is_last   <= pending_items[0].is_last;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: back-pressure in stretches of varying style, plus one long
   // hold-off once a couple of digests are through, so that the output
   // register stalls the engine and the input queue fills up.
   // ------------------------------------------------------------------
   rx_mode_type rx_mode;
   int          mode_left;
   int          hold_left;
   bit          hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_mode   = RX_OPEN;
         mode_left = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!hold_done && digests_done >= 2 && rsp_chan.valid) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (rx_mode)
            RX_OPEN: begin
               rsp_chan.ready <= 1'b1;
            end
            RX_HALF: begin
               rsp_chan.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Monitor: each digest transaction against the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      digest_beat_type due;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (digest_beats_due.size() == 0) begin
            flag_error($sformatf("unexpected digest word %h index %0d",
                                 rsp_chan.digest_word, rsp_chan.word_index));
         end else begin
            due = digest_beats_due.pop_front();
            if (rsp_chan.digest_word !== due.digest_word) begin
               flag_error($sformatf("word %0d: digest_word %h, expected %h", due.word_index,
                                    rsp_chan.digest_word, due.digest_word));
            end
            if (rsp_chan.word_index !== due.word_index) begin
               flag_error($sformatf("word_index %0d, expected %0d",
                                    rsp_chan.word_index, due.word_index));
            end
            if (rsp_chan.last_word !== due.last_word) begin
               flag_error($sformatf("word %0d: last_word %b, expected %b", due.word_index,
                                    rsp_chan.last_word, due.last_word));
            end
         end
         if (rsp_chan.last_word === 1'b1) digests_done <= digests_done + 1;
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long with no transaction on either channel ends the run.
   // ------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("[sha1_message_digest] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

`default_nettype wire
